[rtl/tcmh_pkg.sv]
`timescale 1ns / 1ps
// Package for the track cut / momentum histogram block.
// Types, register indexes, opcodes and reset values; no dependencies.
package tcmh_pkg;

  localparam int NBINS       = 512;
  localparam int COUNT_WIDTH = 32;
  localparam int BIN_W       = $clog2(NBINS);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int MUL_W      = 42;  // 18-bit offset times 24-bit scale

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_HITS     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TERR     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PERR     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_FIT_CONS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_EDGE     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_EDGE    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_BIN_SCALE    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_BINS     = 3'd7;

  // opcodes
  localparam logic [1:0] OP_TRACK     = 2'd0;
  localparam logic [1:0] OP_READ      = 2'd1;
  localparam logic [1:0] OP_READ_CLR  = 2'd2;

  // reset values
  localparam logic [7:0]  RST_MIN_HITS     = 8'd20;
  localparam logic [15:0] RST_MAX_TERR     = 16'd1536;
  localparam logic [15:0] RST_MAX_PERR     = 16'd205;
  localparam logic [31:0] RST_MIN_FIT_CONS = 32'd429497;
  localparam logic [17:0] RST_LOW_EDGE     = 18'd104960;
  localparam logic [17:0] RST_HIGH_EDGE    = 18'd108544;
  localparam logic [23:0] RST_BIN_SCALE    = 24'd6400;
  localparam logic [9:0]  RST_NUM_BINS     = 10'd350;

  // 130 MeV/c in 1/1024 units
  localparam logic [17:0] MOM_CEILING = 18'd133120;

  localparam logic [COUNT_WIDTH-1:0] BIN_MAX = {COUNT_WIDTH{1'b1}};
  localparam logic [31:0]            CTR_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [7:0]       min_active_hits;
    logic [15:0]      max_time_error;
    logic [15:0]      max_momentum_error;
    logic [31:0]      min_fit_consistency;
    logic [17:0]      low_edge;
    logic [17:0]      high_edge;
    logic [23:0]      bin_scale;
    logic [BIN_W-1:0] last_bin;   // clamped num_bins minus one
  } cfg_t;

endpackage

[rtl/tcmh_hist_ram.sv]
`timescale 1ns / 1ps
// Simple dual-port synchronous RAM, one write and one registered read port.
// Holds the histogram bins; no dependencies.
module tcmh_hist_ram #(
  parameter int DEPTH = 512,
  parameter int WIDTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/tcmh_cfg_regs.sv]
`timescale 1ns / 1ps
// Configuration register file for the cut and binning settings.
// Depends on tcmh_pkg.
module tcmh_cfg_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [tcmh_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tcmh_pkg::CFG_DATA_W-1:0]   cfg_data,
  output tcmh_pkg::cfg_t                    cfg
);

  logic [7:0]  min_active_hits;
  logic [15:0] max_time_error;
  logic [15:0] max_momentum_error;
  logic [31:0] min_fit_consistency;
  logic [17:0] low_edge;
  logic [17:0] high_edge;
  logic [23:0] bin_scale;
  logic [9:0]  num_bins;
  logic [tcmh_pkg::BIN_W-1:0] last_bin;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_active_hits     <= tcmh_pkg::RST_MIN_HITS;
      max_time_error      <= tcmh_pkg::RST_MAX_TERR;
      max_momentum_error  <= tcmh_pkg::RST_MAX_PERR;
      min_fit_consistency <= tcmh_pkg::RST_MIN_FIT_CONS;
      low_edge            <= tcmh_pkg::RST_LOW_EDGE;
      high_edge           <= tcmh_pkg::RST_HIGH_EDGE;
      bin_scale           <= tcmh_pkg::RST_BIN_SCALE;
      num_bins            <= tcmh_pkg::RST_NUM_BINS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tcmh_pkg::CFG_MIN_HITS:     min_active_hits     <= cfg_data[7:0];
        tcmh_pkg::CFG_MAX_TERR:     max_time_error      <= cfg_data[15:0];
        tcmh_pkg::CFG_MAX_PERR:     max_momentum_error  <= cfg_data[15:0];
        tcmh_pkg::CFG_MIN_FIT_CONS: min_fit_consistency <= cfg_data[31:0];
        tcmh_pkg::CFG_LOW_EDGE:     low_edge            <= cfg_data[17:0];
        tcmh_pkg::CFG_HIGH_EDGE:    high_edge           <= cfg_data[17:0];
        tcmh_pkg::CFG_BIN_SCALE:    bin_scale           <= cfg_data[23:0];
        tcmh_pkg::CFG_NUM_BINS:     num_bins            <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // zero bins acts as one, more than the store holds acts as the full store
  always_comb begin
    if (num_bins == 10'd0) begin
      last_bin = '0;
    end else if (32'(num_bins) > 32'(tcmh_pkg::NBINS)) begin
      last_bin = tcmh_pkg::BIN_W'(tcmh_pkg::NBINS - 1);
    end else begin
      last_bin = tcmh_pkg::BIN_W'(num_bins - 10'd1);
    end
  end

  assign cfg.min_active_hits     = min_active_hits;
  assign cfg.max_time_error      = max_time_error;
  assign cfg.max_momentum_error  = max_momentum_error;
  assign cfg.min_fit_consistency = min_fit_consistency;
  assign cfg.low_edge            = low_edge;
  assign cfg.high_edge           = high_edge;
  assign cfg.bin_scale           = bin_scale;
  assign cfg.last_bin            = last_bin;

endmodule

[rtl/track_cut_momentum_histogram_core.sv]
`timescale 1ns / 1ps
// Track quality cuts and momentum histogram: top level.
// Accept to result: an unbinned track goes straight to S_FIN, a bin read through S_ADDR and
// S_FIN, a binned track through S_MUL (multiply), S_ADDR (index and RAM read) and S_FIN
// (read-modify-write). One beat in flight at a time; the next waits until S_FIN is left.
// After reset a clearing pass zeroes all 512 histogram bins; input is held off.
// Depends on tcmh_pkg, tcmh_cfg_regs and tcmh_hist_ram.
module track_cut_momentum_histogram_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [tcmh_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tcmh_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      opcode,
  input  logic signed [3:0]               fit_status,
  input  logic [7:0]                      active_hits,
  input  logic [15:0]                     time_error,
  input  logic [15:0]                     momentum_error,
  input  logic [31:0]                     fit_consistency,
  input  logic [17:0]                     momentum,
  input  logic [8:0]                      read_bin,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            track_passed,
  output logic                            track_binned,
  output logic [8:0]                      bin_number,
  output logic [31:0]                     bin_count,
  output logic [31:0]                     total_tracks,
  output logic [31:0]                     passed_tracks,
  output logic [31:0]                     binned_tracks
);

  localparam int BW = tcmh_pkg::BIN_W;
  localparam int CW = tcmh_pkg::COUNT_WIDTH;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_MUL   = 5'b00100,
    S_ADDR  = 5'b01000,
    S_FIN   = 5'b10000
  } state_t;

  tcmh_pkg::cfg_t cfg;

  tcmh_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  state_t state, state_next;
  logic [BW-1:0] clr_addr;

  // beat held while in flight
  logic [1:0]  op;
  logic        passed;
  logic        binned;
  logic [17:0] offset;
  logic [8:0]  rbin;
  logic        rbin_ok;
  logic [tcmh_pkg::MUL_W-1:0] prod;
  logic [BW-1:0] addr;

  logic [31:0] seen_count, pass_count, binned_count;

  // cut evaluation on the accepted beat
  logic cut_pass, in_range;
  logic [tcmh_pkg::MUL_W-17:0] idx_raw;
  logic [BW-1:0] idx;

  logic          ram_we, ram_re;
  logic [BW-1:0] ram_waddr, ram_raddr;
  logic [CW-1:0] ram_wdata, ram_rdata;
  logic [CW-1:0] bin_inc;

  logic fire_in, fin_go;

  assign in_ready = (state == S_IDLE);
  assign fire_in  = in_valid && in_ready;
  assign fin_go   = (state == S_FIN) && (!out_valid || out_ready);

  assign cut_pass = (fit_status == 4'sd1) &&
                    (active_hits >= cfg.min_active_hits) &&
                    (time_error <= cfg.max_time_error) &&
                    (momentum_error <= cfg.max_momentum_error) &&
                    (fit_consistency >= cfg.min_fit_consistency) &&
                    (momentum < tcmh_pkg::MOM_CEILING);
  assign in_range = (momentum >= cfg.low_edge) && (momentum < cfg.high_edge);

  assign idx_raw = prod[tcmh_pkg::MUL_W-1:16];
  always_comb begin
    if (idx_raw > ($bits(idx_raw))'(cfg.last_bin)) begin
      idx = cfg.last_bin;
    end else begin
      idx = BW'(idx_raw);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (clr_addr == BW'(tcmh_pkg::NBINS - 1)) state_next = S_IDLE;
      S_IDLE: begin
        if (fire_in) begin
          if (opcode == tcmh_pkg::OP_TRACK) begin
            state_next = (cut_pass && in_range) ? S_MUL : S_FIN;
          end else if (opcode == tcmh_pkg::OP_READ || opcode == tcmh_pkg::OP_READ_CLR) begin
            state_next = S_ADDR;
          end else begin
            state_next = S_FIN;
          end
        end
      end
      S_MUL:   state_next = S_ADDR;
      S_ADDR:  state_next = S_FIN;
      S_FIN:   if (fin_go) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_addr <= clr_addr + BW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (fire_in) begin
      op      <= opcode;
      passed  <= (opcode == tcmh_pkg::OP_TRACK) && cut_pass;
      binned  <= (opcode == tcmh_pkg::OP_TRACK) && cut_pass && in_range;
      offset  <= momentum - cfg.low_edge;
      rbin    <= read_bin;
      rbin_ok <= 32'(read_bin) < 32'(tcmh_pkg::NBINS);
    end
    if (state == S_MUL) begin
      prod <= tcmh_pkg::MUL_W'(offset) * tcmh_pkg::MUL_W'(cfg.bin_scale);
    end
    if (state == S_ADDR) begin
      addr <= ram_raddr;
    end
  end

  // RAM access: read in S_ADDR, write back in S_FIN; one beat at a time so a
  // read never overlaps a pending write to the same bin
  assign ram_re    = (state == S_ADDR);
  assign ram_raddr = (op == tcmh_pkg::OP_TRACK) ? idx : BW'(rbin);
  assign bin_inc   = (ram_rdata < tcmh_pkg::BIN_MAX) ? ram_rdata + CW'(1) : ram_rdata;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr;
    ram_wdata = '0;
    if (state == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
    end else if (fin_go) begin
      if (binned) begin
        ram_we    = 1'b1;
        ram_wdata = bin_inc;
      end else if (op == tcmh_pkg::OP_READ_CLR && rbin_ok) begin
        ram_we = 1'b1;
      end
    end
  end

  tcmh_hist_ram #(
    .DEPTH (tcmh_pkg::NBINS),
    .WIDTH (CW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // running counters and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      seen_count   <= '0;
      pass_count   <= '0;
      binned_count <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (fin_go) begin
        out_valid <= 1'b1;
        if (op == tcmh_pkg::OP_TRACK && seen_count != tcmh_pkg::CTR_MAX) begin
          seen_count <= seen_count + 32'd1;
        end
        if (passed && pass_count != tcmh_pkg::CTR_MAX) pass_count <= pass_count + 32'd1;
        if (binned && binned_count != tcmh_pkg::CTR_MAX) begin
          binned_count <= binned_count + 32'd1;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign total_tracks  = seen_count;
  assign passed_tracks = pass_count;
  assign binned_tracks = binned_count;

  always_ff @(posedge clk) begin
    if (fin_go) begin
      track_passed <= passed;
      track_binned <= binned;
      if (binned) begin
        bin_number <= 9'(addr);
        bin_count  <= 32'(bin_inc);
      end else if (op == tcmh_pkg::OP_READ || op == tcmh_pkg::OP_READ_CLR) begin
        bin_number <= rbin;
        bin_count  <= rbin_ok ? 32'(ram_rdata) : 32'd0;
      end else begin
        bin_number <= '0;
        bin_count  <= '0;
      end
    end
  end

endmodule

[tb/tcmh_tb_pkg.sv]
`timescale 1ns / 1ps
// Beat types and the histogram scoreboard for the track cut / momentum histogram tests.
// Depends on tcmh_pkg for register indexes, opcodes, reset values and sizes.
package tcmh_tb_pkg;
  import tcmh_pkg::*;

  // opcode with no defined action: nothing changes, counters reported
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]        opcode;
    logic signed [3:0] fit_status;
    logic [7:0]        active_hits;
    logic [15:0]       time_error;
    logic [15:0]       momentum_error;
    logic [31:0]       fit_consistency;
    logic [17:0]       momentum;
    logic [8:0]        read_bin;
  } track_beat_t;

  typedef struct packed {
    logic        track_passed;
    logic        track_binned;
    logic [8:0]  bin_number;
    logic [31:0] bin_count;
    logic [31:0] total_tracks;
    logic [31:0] passed_tracks;
    logic [31:0] binned_tracks;
  } hist_result_t;

  class hist_scoreboard;
    logic [7:0]  hits_min;
    logic [15:0] terr_max;
    logic [15:0] perr_max;
    logic [31:0] fcon_min;
    logic [17:0] edge_lo;
    logic [17:0] edge_hi;
    logic [23:0] scale;
    logic [9:0]  bins_used;

    logic [COUNT_WIDTH-1:0] bin_store [NBINS];
    logic [31:0] seen_total;
    logic [31:0] pass_total;
    logic [31:0] binned_total;

    hist_result_t expected_q[$];
    int unsigned  errors;
    int unsigned  checked;

    function new();
      hits_min  = RST_MIN_HITS;
      terr_max  = RST_MAX_TERR;
      perr_max  = RST_MAX_PERR;
      fcon_min  = RST_MIN_FIT_CONS;
      edge_lo   = RST_LOW_EDGE;
      edge_hi   = RST_HIGH_EDGE;
      scale     = RST_BIN_SCALE;
      bins_used = RST_NUM_BINS;
      foreach (bin_store[i]) bin_store[i] = '0;
      seen_total   = '0;
      pass_total   = '0;
      binned_total = '0;
      errors  = 0;
      checked = 0;
    endfunction

    function void write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
      case (idx)
        CFG_MIN_HITS:     hits_min  = data[7:0];
        CFG_MAX_TERR:     terr_max  = data[15:0];
        CFG_MAX_PERR:     perr_max  = data[15:0];
        CFG_MIN_FIT_CONS: fcon_min  = data;
        CFG_LOW_EDGE:     edge_lo   = data[17:0];
        CFG_HIGH_EDGE:    edge_hi   = data[17:0];
        CFG_BIN_SCALE:    scale     = data[23:0];
        CFG_NUM_BINS:     bins_used = data[9:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] bump(input logic [31:0] v);
      return (v == CTR_MAX) ? v : v + 32'd1;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // works out the histogram result of one accepted beat and queues it
    function void note_beat(input track_beat_t b);
      hist_result_t     r;
      int unsigned      nb;
      longint unsigned  idx;
      r = '0;
      case (b.opcode)
        OP_TRACK: begin
          seen_total = bump(seen_total);
          if (b.fit_status == 4'sd1 && b.active_hits >= hits_min &&
              b.time_error <= terr_max && b.momentum_error <= perr_max &&
              b.fit_consistency >= fcon_min && b.momentum < MOM_CEILING) begin
            r.track_passed = 1'b1;
            pass_total = bump(pass_total);
            if (b.momentum >= edge_lo && b.momentum < edge_hi) begin
              nb = bins_used;
              if (nb == 0) nb = 1;
              if (nb > NBINS) nb = NBINS;
              idx = (64'(b.momentum - edge_lo) * 64'(scale)) >> 16;
              if (idx >= nb) idx = nb - 1;
              if (bin_store[idx] != BIN_MAX) bin_store[idx] = bin_store[idx] + 1'b1;
              r.track_binned = 1'b1;
              r.bin_number   = 9'(idx);
              r.bin_count    = 32'(bin_store[idx]);
              binned_total   = bump(binned_total);
            end
          end
        end
        OP_READ, OP_READ_CLR: begin
          r.bin_number = b.read_bin;
          r.bin_count  = 32'(bin_store[b.read_bin]);
          if (b.opcode == OP_READ_CLR) bin_store[b.read_bin] = '0;
        end
        default: ;
      endcase
      r.total_tracks  = seen_total;
      r.passed_tracks = pass_total;
      r.binned_tracks = binned_total;
      expected_q.insert(expected_q.size(), r);
    endfunction

    task report(input string msg);
      errors++;
      $display("[%0t] mismatch on result %0d: %s", $time, checked, msg);
    endtask

    task cmp(input string field, input logic [31:0] got, input logic [31:0] want);
      if (got !== want) report($sformatf("%s got %0h want %0h", field, got, want));
    endtask

    task check_result(input hist_result_t got);
      hist_result_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("result with nothing outstanding, bin %0d count %0d",
                         got.bin_number, got.bin_count));
      end else begin
        want = expected_q.pop_front();
        cmp("track_passed", 32'(got.track_passed), 32'(want.track_passed));
        cmp("track_binned", 32'(got.track_binned), 32'(want.track_binned));
        cmp("bin_number", 32'(got.bin_number), 32'(want.bin_number));
        cmp("bin_count", got.bin_count, want.bin_count);
        cmp("total_tracks", got.total_tracks, want.total_tracks);
        cmp("passed_tracks", got.passed_tracks, want.passed_tracks);
        cmp("binned_tracks", got.binned_tracks, want.binned_tracks);
      end
      checked++;
    endtask
  endclass

endpackage

[tb/tb_top.sv]
`timescale 1ns / 1ps
// Top of the track cut / momentum histogram testbench: clock, reset, beat drivers,
// result monitor and stall watchdog. Depends on tcmh_pkg, tcmh_tb_pkg and the core.
module tb_top;
  import tcmh_pkg::*;
  import tcmh_tb_pkg::*;

  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int HOLD_OFF_CYCLES = 300;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [1:0]            opcode = OP_TRACK;
  logic signed [3:0]     fit_status = '0;
  logic [7:0]            active_hits = '0;
  logic [15:0]           time_error = '0;
  logic [15:0]           momentum_error = '0;
  logic [31:0]           fit_consistency = '0;
  logic [17:0]           momentum = '0;
  logic [8:0]            read_bin = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b1;
  logic                  track_passed;
  logic                  track_binned;
  logic [8:0]            bin_number;
  logic [31:0]           bin_count;
  logic [31:0]           total_tracks;
  logic [31:0]           passed_tracks;
  logic [31:0]           binned_tracks;

  hist_scoreboard sb;
  int unsigned    idle_pct = 0;
  int unsigned    results_seen = 0;
  int unsigned    stall_cycles = 0;

  always #2 clk = ~clk;

  track_cut_momentum_histogram_core DUT (.*);

  // ---------------------------------------------------------------- drivers
  task automatic send_beat(input track_beat_t b);
    if (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(19, 1)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    opcode          <= b.opcode;
    fit_status      <= b.fit_status;
    active_hits     <= b.active_hits;
    time_error      <= b.time_error;
    momentum_error  <= b.momentum_error;
    fit_consistency <= b.fit_consistency;
    momentum        <= b.momentum;
    read_bin        <= b.read_bin;
    do @(posedge clk); while (!in_ready);
    sb.note_beat(b);
  endtask

  // let the block go quiet before touching the registers
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  task automatic program_regs(input logic [7:0] hits, input logic [15:0] terr,
                              input logic [15:0] perr, input logic [31:0] fcon,
                              input logic [17:0] lo, input logic [17:0] hi,
                              input logic [23:0] scl, input logic [9:0] nbins);
    drain();
    cfg_write(CFG_MIN_HITS, 32'(hits));
    cfg_write(CFG_MAX_TERR, 32'(terr));
    cfg_write(CFG_MAX_PERR, 32'(perr));
    cfg_write(CFG_MIN_FIT_CONS, fcon);
    cfg_write(CFG_LOW_EDGE, 32'(lo));
    cfg_write(CFG_HIGH_EDGE, 32'(hi));
    cfg_write(CFG_BIN_SCALE, 32'(scl));
    cfg_write(CFG_NUM_BINS, 32'(nbins));
  endtask

  task automatic random_regs();
    logic [17:0] lo;
    lo = 18'($urandom_range(133000, 60000));
    program_regs(8'($urandom_range(40, 0)), 16'($urandom), 16'($urandom), $urandom,
                 lo, lo + 18'($urandom_range(6000, 0)),
                 ($urandom_range(3, 0) == 0) ? 24'($urandom) : 24'($urandom_range(40000, 50)),
                 10'($urandom_range(1023, 0)));
  endtask

  // track sitting on every cut boundary on the passing side
  function automatic track_beat_t good_track(input logic [17:0] mom);
    track_beat_t b;
    b = '0;
    b.opcode          = OP_TRACK;
    b.fit_status      = 4'sd1;
    b.active_hits     = sb.hits_min;
    b.time_error      = sb.terr_max;
    b.momentum_error  = sb.perr_max;
    b.fit_consistency = sb.fcon_min;
    b.momentum        = mom;
    b.read_bin        = 9'($urandom);
    return b;
  endfunction

  // mostly well-formed tracks inside the cuts, some spoilt, plus reads and noise
  function automatic track_beat_t make_beat();
    track_beat_t b;
    int unsigned pick;
    int unsigned nb;
    b.opcode          = 2'($urandom_range(3, 0));
    b.fit_status      = 4'($urandom);
    b.active_hits     = 8'($urandom);
    b.time_error      = 16'($urandom);
    b.momentum_error  = 16'($urandom);
    b.fit_consistency = $urandom;
    b.momentum        = 18'($urandom);
    b.read_bin        = 9'($urandom);
    nb = (sb.bins_used == 0) ? 1 : ((sb.bins_used > NBINS) ? NBINS : sb.bins_used);
    pick = $urandom_range(99, 0);
    if (pick < 65) begin
      b.opcode          = OP_TRACK;
      b.fit_status      = 4'sd1;
      b.active_hits     = 8'($urandom_range(255, sb.hits_min));
      b.time_error      = 16'($urandom_range(sb.terr_max, 0));
      b.momentum_error  = 16'($urandom_range(sb.perr_max, 0));
      b.fit_consistency = $urandom_range(32'hFFFF_FFFF, sb.fcon_min);
      if (sb.edge_lo < sb.edge_hi && $urandom_range(9, 0) != 0) begin
        case ($urandom_range(9, 0))
          0:       b.momentum = sb.edge_lo;
          1:       b.momentum = sb.edge_hi - 1'b1;
          default: b.momentum = 18'($urandom_range(sb.edge_hi - 1, sb.edge_lo));
        endcase
      end
      if ($urandom_range(3, 0) == 0) begin
        case ($urandom_range(5, 0))
          0: b.fit_status = 4'sd1 + 4'($urandom_range(15, 1));
          1: if (sb.hits_min != 0) b.active_hits = sb.hits_min - 1'b1;
          2: if (sb.terr_max != 16'hFFFF) b.time_error = sb.terr_max + 1'b1;
          3: if (sb.perr_max != 16'hFFFF) b.momentum_error = sb.perr_max + 1'b1;
          4: if (sb.fcon_min != 0) b.fit_consistency = sb.fcon_min - 1'b1;
          default: b.momentum = MOM_CEILING + 18'($urandom_range(1000, 0));
        endcase
      end
    end else if (pick < 85) begin
      b.opcode = $urandom_range(1, 0) ? OP_READ : OP_READ_CLR;
      if ($urandom_range(1, 0)) b.read_bin = 9'($urandom_range(nb - 1, 0));
    end
    return b;
  endfunction

  task automatic run_random(input int unsigned count);
    repeat (count) send_beat(make_beat());
  endtask

  // ---------------------------------------------------------------- result side
  initial begin : sink
    int unsigned gap;
    bit          held;
    gap  = 0;
    held = 1'b0;
    wait (!rst);
    forever begin
      @(posedge clk);
      if (!held && results_seen >= 120) begin
        // long hold-off so the block backs up and stalls its input
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        out_ready <= 1'b1;
      end else if (gap != 0) begin
        out_ready <= 1'b0;
        gap--;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(99, 0) < idle_pct / 2) gap = $urandom_range(19, 1);
      end
    end
  end

  always @(posedge clk) begin : result_mon
    hist_result_t got;
    if (!rst && out_valid && out_ready) begin
      got.track_passed  = track_passed;
      got.track_binned  = track_binned;
      got.bin_number    = bin_number;
      got.bin_count     = bin_count;
      got.total_tracks  = total_tracks;
      got.passed_tracks = passed_tracks;
      got.binned_tracks = binned_tracks;
      results_seen++;
      sb.check_result(got);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus
  initial begin : stimulus
    track_beat_t b;
    sb = new();
    idle_pct = 20;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset settings: edges, every cut on both sides, reads and the unused opcode
    b = good_track(sb.edge_lo);
    send_beat(b);
    send_beat(b);
    send_beat(good_track(sb.edge_hi - 1'b1));
    send_beat(good_track(sb.edge_hi));
    send_beat(good_track(sb.edge_lo - 1'b1));
    send_beat(good_track(MOM_CEILING - 1'b1));
    send_beat(good_track(MOM_CEILING));
    send_beat(good_track(18'h3FFFF));
    b = good_track(sb.edge_lo);
    b.fit_status = 4'sd0;
    send_beat(b);
    b.fit_status = -4'sd8;
    send_beat(b);
    b.fit_status = 4'sd7;
    send_beat(b);
    b = good_track(sb.edge_lo);
    b.active_hits = sb.hits_min - 1'b1;
    send_beat(b);
    b = good_track(sb.edge_lo);
    b.time_error = sb.terr_max + 1'b1;
    send_beat(b);
    b = good_track(sb.edge_lo);
    b.momentum_error = sb.perr_max + 1'b1;
    send_beat(b);
    b = good_track(sb.edge_lo);
    b.fit_consistency = sb.fcon_min - 1'b1;
    send_beat(b);
    b = '1;
    b.opcode = OP_TRACK;
    send_beat(b);
    b = '0;
    send_beat(b);
    b.opcode = OP_READ;
    send_beat(b);
    b.opcode = OP_READ_CLR;
    send_beat(b);
    b.opcode = OP_READ;
    send_beat(b);
    b.read_bin = 9'd349;
    send_beat(b);
    b.read_bin = 9'h1FF;
    send_beat(b);
    b = '1;
    b.opcode = OP_UNUSED;
    send_beat(b);
    send_beat(good_track(sb.edge_lo));
    run_random(80);

    // wide open cuts, one bin, tiny scale
    program_regs(8'd0, 16'hFFFF, 16'hFFFF, 32'd0, 18'd0, 18'h3FFFF, 24'd1, 10'd1);
    idle_pct = 0;
    run_random(50);

    // tightest cuts, empty range, zero bins
    program_regs(8'hFF, 16'd0, 16'd0, 32'hFFFF_FFFF, 18'h3FFFF, 18'd0, 24'hFFFFFF, 10'd0);
    idle_pct = 40;
    run_random(30);

    // range past the ceiling, huge scale so everything clamps, bin count over the limit
    program_regs(8'd10, 16'd1000, 16'd300, 32'h4000_0000, 18'd100000, 18'd133500,
                 24'hFFFFFF, 10'h3FF);
    idle_pct = 15;
    run_random(60);

    // all 512 bins spread up to the ceiling
    program_regs(8'd5, 16'd2000, 16'd400, 32'd1000, 18'd130000, 18'd134000, 24'd10754,
                 10'd512);
    idle_pct = 25;
    run_random(80);

    random_regs();
    idle_pct = 10;
    run_random(60);
    random_regs();
    idle_pct = 30;
    run_random(60);

    // closing stretch with no idling on either side
    program_regs(8'd5, 16'd2000, 16'd400, 32'd1000, 18'd130000, 18'd134000, 24'd10754,
                 10'd512);
    idle_pct = 0;
    run_random(40);

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
